// ===== sv/scfb_pkg.sv =====
// ----------------------------------------------------------------------------
// scfb_pkg
// Shared types, frame constants and the CRC-8 byte update of the frame builder.
// ----------------------------------------------------------------------------
package scfb_pkg;

    localparam logic [7:0] FRAME_START = 8'h53;
    localparam logic [7:0] FRAME_END   = 8'h45;
    localparam logic [7:0] CRC_POLY    = 8'hD5;
    localparam logic [7:0] CRC_INIT    = 8'hFF;
    localparam logic [7:0] NODE_RESET  = 8'h01;

    localparam logic [1:0] OP_CONTROL = 2'd0;
    localparam logic [1:0] OP_MODE    = 2'd1;
    localparam logic [1:0] OP_TARGET  = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    localparam logic [1:0] SEL_ZERO = 2'd0;
    localparam logic [1:0] SEL_ONE  = 2'd1;
    localparam logic [1:0] SEL_TWO  = 2'd2;

    localparam logic [3:0] LEN_CONTROL = 4'h6;
    localparam logic [3:0] LEN_MODE    = 4'h8;
    localparam logic [3:0] LEN_TARGET  = 4'hB;
    localparam logic [3:0] LEN_READ    = 4'h7;

    localparam logic [7:0] CMD_CONTROL = 8'h04;
    localparam logic [7:0] CMD_WRITE   = 8'h02;
    localparam logic [7:0] CMD_READ    = 8'h01;

    localparam logic [7:0] IDX_HIGH     = 8'h60;
    localparam logic [7:0] IDX_SPEED    = 8'hFF;
    localparam logic [7:0] IDX_POSITION = 8'h7A;
    localparam logic [7:0] IDX_TORQUE   = 8'h77;
    localparam logic [7:0] IDX_RD_SPEED = 8'h6C;
    localparam logic [7:0] IDX_RD_POS   = 8'h64;
    localparam logic [7:0] MODE_ONE     = 8'h01;
    localparam logic [7:0] MODE_THREE   = 8'h03;

    typedef logic [3:0] t_idx;

    typedef struct packed {
        logic capture;
        logic emit;
        t_idx idx;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        t_idx last_idx;
    } t_status;

    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/scfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// scfb_ctrl
// Sequencer that accepts a request and steps through the bytes of its frame.
// ----------------------------------------------------------------------------
module scfb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  scfb_pkg::t_status i_status,
    output scfb_pkg::t_cmd   o_cmd
);
    import scfb_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    logic r_state, n_state;
    t_idx r_idx, n_idx;
    logic emit;

    assign o_ready = (r_state == ST_IDLE);
    assign emit    = (r_state == ST_SEND) && i_status.out_free;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SEND;
                    n_idx   = '0;
                end
            end
            ST_SEND: begin
                if (emit) begin
                    if (r_idx == i_status.last_idx) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + t_idx'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_cmd.capture = o_ready && i_valid;
    assign o_cmd.emit    = emit;
    assign o_cmd.idx     = r_idx;

endmodule

// ===== sv/scfb_datapath.sv =====
// ----------------------------------------------------------------------------
// scfb_datapath
// Request registers, frame byte selection, running CRC and output register.
// ----------------------------------------------------------------------------
module scfb_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_operation,
    input  logic [1:0]         i_object_select,
    input  logic [7:0]         i_control_byte,
    input  logic signed [31:0] i_target_value,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [7:0]         o_tx_byte,
    output logic               o_last_byte,
    input  scfb_pkg::t_cmd     i_cmd,
    output scfb_pkg::t_status  o_status
);
    import scfb_pkg::*;

    logic [7:0]  r_node;
    logic [1:0]  r_op;
    logic [1:0]  r_sel;
    logic [7:0]  r_ctrl;
    logic [31:0] r_data;
    logic [7:0]  r_crc;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_last;

    t_idx       len;
    logic [7:0] body;
    logic [7:0] byte_sel;
    logic       in_crc;

    always_comb begin
        unique case (r_op)
            OP_CONTROL: len = LEN_CONTROL;
            OP_MODE:    len = LEN_MODE;
            OP_TARGET:  len = LEN_TARGET;
            default:    len = LEN_READ;
        endcase
    end

    always_comb begin
        body = 8'h00;
        case (i_cmd.idx)
            4'd0: body = FRAME_START;
            4'd1: body = {4'h0, len};
            4'd2: body = r_node;
            4'd3: begin
                case (r_op)
                    OP_CONTROL: body = CMD_CONTROL;
                    OP_READ:    body = CMD_READ;
                    default:    body = CMD_WRITE;
                endcase
            end
            4'd4: begin
                case (r_op)
                    OP_CONTROL: body = r_ctrl;
                    OP_MODE:    body = IDX_HIGH;
                    OP_TARGET:  body = (r_sel == SEL_ONE) ? IDX_POSITION : IDX_SPEED;
                    default: begin
                        if (r_sel == SEL_ONE) begin
                            body = IDX_RD_SPEED;
                        end else if (r_sel == SEL_TWO) begin
                            body = IDX_RD_POS;
                        end else begin
                            body = IDX_TORQUE;
                        end
                    end
                endcase
            end
            4'd5: body = (r_op == OP_CONTROL) ? 8'h00 : IDX_HIGH;
            4'd6: body = 8'h00;
            4'd7: begin
                if (r_op == OP_MODE) begin
                    body = (r_sel == SEL_ONE) ? MODE_THREE : MODE_ONE;
                end else begin
                    body = r_data[7:0];
                end
            end
            4'd8:    body = r_data[15:8];
            4'd9:    body = r_data[23:16];
            4'd10:   body = r_data[31:24];
            default: body = 8'h00;
        endcase
    end

    always_comb begin
        if (i_cmd.idx == len) begin
            byte_sel = r_crc;
        end else if (i_cmd.idx == o_status.last_idx) begin
            byte_sel = FRAME_END;
        end else begin
            byte_sel = body;
        end
    end

    assign in_crc = (i_cmd.idx != '0) && (i_cmd.idx < len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node  <= NODE_RESET;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node <= i_cfg_wdata;
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_sel  <= i_object_select;
            r_ctrl <= i_control_byte;
            r_data <= i_target_value;
            r_crc  <= CRC_INIT;
        end else if (i_cmd.emit && in_crc) begin
            r_crc <= crc_update(r_crc, byte_sel);
        end
        if (i_cmd.emit) begin
            r_byte <= byte_sel;
            r_last <= (i_cmd.idx == o_status.last_idx);
        end
    end

    assign o_status.out_free = !r_valid || i_ready;
    assign o_status.last_idx = len + t_idx'(1);

    assign o_valid     = r_valid;
    assign o_tx_byte   = r_byte;
    assign o_last_byte = r_last;

endmodule

// ===== sv/servo_command_frame_builder.sv =====
// ----------------------------------------------------------------------------
// servo_command_frame_builder
// Builds the serial frame of one servo command and sends it byte by byte.
// ----------------------------------------------------------------------------
// A request word (operation, object select, control byte, target value) is
// taken on the input channel when i_valid and o_ready are both high. The block
// then sends the frame 'S', length, node, command, body, CRC-8, 'E' on the
// output channel, one word per cycle while i_ready stays high, with o_last_byte
// high on the closing 'E'. A frame of length L (6, 7, 8 or 11) gives L+2 words.
// The byte sequencer produces one byte per cycle when not stalled and updates
// the CRC with each byte from the length through the body; o_ready is high
// only between frames. When the receiver holds i_ready low the output register
// keeps its word and the sequencer waits. The user must write the node number
// through i_cfg_we and i_cfg_wdata only while the block is idle; the block
// itself does not enforce this. Reset returns the sequencer to idle, clears
// the output valid and sets the node number to 1.
// ----------------------------------------------------------------------------
module servo_command_frame_builder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_operation,
    input  logic [1:0]         i_object_select,
    input  logic [7:0]         i_control_byte,
    input  logic signed [31:0] i_target_value,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_tx_byte,
    output logic               o_last_byte
);
    import scfb_pkg::*;

    t_cmd    cmd;
    t_status status;

    scfb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    scfb_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_operation     (i_operation),
        .i_object_select (i_object_select),
        .i_control_byte  (i_control_byte),
        .i_target_value  (i_target_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_tx_byte       (o_tx_byte),
        .o_last_byte     (o_last_byte),
        .i_cmd           (cmd),
        .o_status        (status)
    );

endmodule
